### rtl/cqf_pkg.sv
package cqf_pkg;

    // field widths fixed by the request and result formats
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 4;

    // sizing
    localparam int DEPTH_DEFAULT  = 8;
    localparam int CAPACITY_RESET = 5;
    localparam int MAX_SHOW       = 8;
    localparam int SHOW_W         = $clog2(MAX_SHOW);

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SHOW = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic                take;
        logic                enq;
        logic                deq;
        logic                show_start;
        logic                show_step;
        logic                front_capture;
        logic                out_reply;
        logic                out_show;
        logic [STATUS_W-1:0] code;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic single;
        logic show_last;
        logic out_free;
    } stat_t;

endpackage

### rtl/cqf_req_if.sv
interface cqf_req_if;
    logic                              valid;
    logic                              ready;
    logic [cqf_pkg::KIND_W-1:0]        kind;
    logic signed [cqf_pkg::DATA_W-1:0] value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

### rtl/cqf_rsp_if.sv
interface cqf_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [cqf_pkg::STATUS_W-1:0]      status;
    logic                              is_empty;
    logic                              is_full;
    logic signed [cqf_pkg::DATA_W-1:0] front_value;
    logic signed [cqf_pkg::DATA_W-1:0] shown_value;
    logic                              last;

    modport source (output valid, status, is_empty, is_full, front_value, shown_value, last,
                    input ready);
    modport sink   (input valid, status, is_empty, is_full, front_value, shown_value, last,
                    output ready);
endinterface

### rtl/cqf_datapath.sv
module cqf_datapath #(
    parameter int DEPTH = cqf_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cqf_pkg::CAP_W-1:0]         cfg_wr_data,
    input  logic signed [cqf_pkg::DATA_W-1:0] req_value,
    input  cqf_pkg::cmd_t                     cmd,
    output cqf_pkg::stat_t                    stat,
    cqf_rsp_if.source                         rsp
);

    localparam int IW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int XW      = (CW > cqf_pkg::CAP_W) ? CW : cqf_pkg::CAP_W;
    localparam int CAP_RST = (cqf_pkg::CAPACITY_RESET > DEPTH) ? DEPTH
                                                               : cqf_pkg::CAPACITY_RESET;

    // slot storage and registered read
    logic signed [cqf_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [cqf_pkg::DATA_W-1:0] rd_data_reg;
    logic signed [cqf_pkg::DATA_W-1:0] front_reg;
    logic signed [cqf_pkg::DATA_W-1:0] value_reg;

    // indices and capacity
    logic [IW-1:0]              head_reg;
    logic [IW-1:0]              tail_reg;
    logic [IW-1:0]              cur_reg;
    logic [cqf_pkg::SHOW_W-1:0] show_cnt_reg;
    logic                       empty_reg;
    logic [CW-1:0]              cap_reg;

    // output register
    logic                                out_valid_reg;
    logic [cqf_pkg::STATUS_W-1:0]        out_status_reg;
    logic                                out_empty_reg;
    logic                                out_full_reg;
    logic signed [cqf_pkg::DATA_W-1:0]   out_front_reg;
    logic signed [cqf_pkg::DATA_W-1:0]   out_shown_reg;
    logic                                out_last_reg;

    logic [IW-1:0] head_nxt;
    logic [IW-1:0] tail_nxt;
    logic [IW-1:0] cur_nxt;
    logic [IW-1:0] enq_addr;
    logic [IW-1:0] rd_addr;
    logic          rd_en;
    logic          full;
    logic          single;
    logic          show_last;
    logic          out_load;
    logic [XW-1:0] cap_x;
    logic [CW-1:0] cap_wr;

    // increment with wrap at the capacity in use
    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i,
                                               input logic [CW-1:0] cap);
        logic [IW:0] n;
        n = {1'b0, i} + (IW+1)'(1);
        wrap_inc = (n >= (IW+1)'(cap)) ? '0 : n[IW-1:0];
    endfunction

    assign head_nxt = wrap_inc(head_reg, cap_reg);
    assign tail_nxt = wrap_inc(tail_reg, cap_reg);
    assign cur_nxt  = wrap_inc(cur_reg, cap_reg);

    // capacity clamp: zero acts as one, above depth acts as depth
    assign cap_x  = XW'(cfg_wr_data);
    assign cap_wr = (cap_x == '0)          ? CW'(1) :
                    (cap_x > XW'(DEPTH))   ? CW'(DEPTH) : CW'(cap_x);

    // queue status
    assign full      = !empty_reg && (tail_nxt == head_reg);
    assign single    = (head_reg == tail_reg);
    assign show_last = (cur_reg == tail_reg) ||
                       (show_cnt_reg == cqf_pkg::SHOW_W'(cqf_pkg::MAX_SHOW - 1));
    assign out_load  = cmd.out_reply || cmd.out_show;

    assign stat.empty     = empty_reg;
    assign stat.full      = full;
    assign stat.single    = single;
    assign stat.show_last = show_last;
    assign stat.out_free  = !out_valid_reg || rsp.ready;

    assign enq_addr = empty_reg ? head_reg : tail_nxt;
    assign rd_en    = (cmd.deq && !single) || cmd.show_start || cmd.show_step;
    assign rd_addr  = cmd.show_step  ? cur_nxt  :
                      cmd.show_start ? head_reg : head_nxt;

    // index and capacity registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            cur_reg      <= '0;
            show_cnt_reg <= '0;
            empty_reg    <= 1'b1;
            cap_reg      <= CW'(CAP_RST);
        end
        else if (cfg_wr_en)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            cap_reg   <= cap_wr;
        end
        else
        begin
            if (cmd.enq)
            begin
                tail_reg  <= enq_addr;
                empty_reg <= 1'b0;
            end
            if (cmd.deq)
            begin
                if (single)
                begin
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    empty_reg <= 1'b1;
                end
                else
                begin
                    head_reg <= head_nxt;
                end
            end
            if (cmd.show_start)
            begin
                cur_reg      <= head_reg;
                show_cnt_reg <= '0;
            end
            if (cmd.show_step)
            begin
                cur_reg      <= cur_nxt;
                show_cnt_reg <= show_cnt_reg + cqf_pkg::SHOW_W'(1);
            end
        end
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (cmd.enq)
            mem[enq_addr] <= value_reg;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // request value and front copy
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            value_reg <= req_value;
        if (cmd.enq && empty_reg)
            front_reg <= value_reg;
        else if (cmd.front_capture)
            front_reg <= rd_data_reg;
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= cmd.out_show ? cqf_pkg::STATUS_OK : cmd.code;
            out_empty_reg  <= empty_reg;
            out_full_reg   <= full;
            out_front_reg  <= empty_reg ? '0 : front_reg;
            out_shown_reg  <= cmd.out_show ? rd_data_reg : '0;
            out_last_reg   <= cmd.out_show ? show_last : 1'b1;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.is_empty    = out_empty_reg;
    assign rsp.is_full     = out_full_reg;
    assign rsp.front_value = out_front_reg;
    assign rsp.shown_value = out_shown_reg;
    assign rsp.last        = out_last_reg;

    // checks
    a_enq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq |-> !full)
        else $error("enqueue issued on a full queue");

    a_deq_fetch_front: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.deq && !single) |=> cmd.front_capture)
        else $error("new front not captured after dequeue");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, head_reg} < (IW+1)'(cap_reg)) && ({1'b0, tail_reg} < (IW+1)'(cap_reg)))
        else $error("queue index beyond capacity in use");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> ($stable(rsp.last) && rsp.valid))
        else $error("pending result overwritten while stalled");

endmodule

### rtl/cqf_ctrl.sv
module cqf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    cqf_req_if.sink        req,
    input  cqf_pkg::stat_t stat,
    output cqf_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_REPLY = 3'd3;
    localparam logic [2:0] ST_SHOW  = 3'd4;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [cqf_pkg::KIND_W-1:0]   kind_reg;
    logic [cqf_pkg::KIND_W-1:0]   kind_next;
    logic [cqf_pkg::STATUS_W-1:0] code_reg;
    logic [cqf_pkg::STATUS_W-1:0] code_next;

    assign req.ready = (state_reg == ST_IDLE);

    // sequencing of one request
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd.take   = 1'b1;
                    kind_next  = req.kind;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (kind_reg)
                    cqf_pkg::KIND_ENQ:
                    begin
                        state_next = ST_REPLY;
                        if (stat.full)
                            code_next = cqf_pkg::STATUS_FULL;
                        else
                        begin
                            cmd.enq   = 1'b1;
                            code_next = cqf_pkg::STATUS_OK;
                        end
                    end
                    cqf_pkg::KIND_DEQ:
                    begin
                        if (stat.empty)
                        begin
                            code_next  = cqf_pkg::STATUS_EMPTY;
                            state_next = ST_REPLY;
                        end
                        else
                        begin
                            cmd.deq    = 1'b1;
                            code_next  = cqf_pkg::STATUS_OK;
                            state_next = stat.single ? ST_REPLY : ST_FETCH;
                        end
                    end
                    cqf_pkg::KIND_SHOW:
                    begin
                        if (stat.empty)
                        begin
                            code_next  = cqf_pkg::STATUS_EMPTY;
                            state_next = ST_REPLY;
                        end
                        else
                        begin
                            cmd.show_start = 1'b1;
                            state_next     = ST_SHOW;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FETCH:
            begin
                cmd.front_capture = 1'b1;
                state_next        = ST_REPLY;
            end
            ST_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.out_reply = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SHOW:
            begin
                if (stat.out_free)
                begin
                    cmd.out_show = 1'b1;
                    if (stat.show_last)
                        state_next = ST_IDLE;
                    else
                        cmd.show_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= cqf_pkg::KIND_NONE;
            code_reg  <= cqf_pkg::STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            code_reg  <= code_next;
        end
    end

endmodule

### rtl/circular_queue_fifo.sv
// Circular queue of signed 32-bit values with a run-time capacity.
// Channels: req (sink) takes one request per handshake: kind enqueue,
// dequeue or display, plus the value to enqueue. rsp (source) gives result
// items with status, empty and full flags, front value, shown value and a
// last mark on the final result of each request. Kind 3 gives no result.
// cfg_wr_en/cfg_wr_data set the capacity (zero acts as one, above DEPTH acts
// as DEPTH) and empty the queue; write only while the block is idle.
// Sequence: a request is taken in IDLE and carried out in EXEC; an enqueue
// or a rejected request then loads its result in REPLY and the controller
// goes back to IDLE for the next request; a dequeue that leaves elements
// passes through FETCH first to read the new front from the slot memory.
// A display passes EXEC, then emits one result per cycle in SHOW while the
// output register is free, at the pace of the slot memory's one read port.
// Reset empties the queue and sets the capacity to 5 (or DEPTH if smaller);
// slot contents are left as they are.
// Results wait in an output register while rsp.ready is low; the controller
// holds its sequence until that register is free.
module circular_queue_fifo #(
    parameter int DEPTH = cqf_pkg::DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [cqf_pkg::CAP_W-1:0] cfg_wr_data,
    cqf_req_if.sink                   req,
    cqf_rsp_if.source                 rsp
);

    cqf_pkg::cmd_t  cmd;
    cqf_pkg::stat_t stat;

    // request sequencer
    cqf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (stat),
        .cmd   (cmd)
    );

    // indices, slot memory and output register
    cqf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_value   (req.value),
        .cmd         (cmd),
        .stat        (stat),
        .rsp         (rsp)
    );

endmodule
